// ===== design/pyss_pkg.sv =====
// ----------------------------------------------------------------------------
// pyss_pkg: shared types and constants of the PGM 4:2:0 stream splitter.
// Holds the parser phases, result codes, the result bundle and the small
// character and arithmetic helpers used by the header parser.
// ----------------------------------------------------------------------------
package pyss_pkg;

	// Default largest accepted frame dimension.
	localparam int unsigned MAX_DIM_DEF = 4096;

	// Header field accumulators saturate here.
	localparam logic [15:0] ACC_MAX = 16'hFFFF;

	// The only maxval that the first header may carry.
	localparam logic [15:0] MAXVAL_OK = 16'd255;

	// Header field indexes.
	localparam logic [1:0] FIELD_COLS = 2'd0;
	localparam logic [1:0] FIELD_ROWS = 2'd1;
	localparam logic [1:0] FIELD_MAXV = 2'd2;

	// Characters of interest in the header.
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Reciprocal of three scaled by 2**17, exact for 16-bit dividends.
	localparam logic [16:0] RECIP3   = 17'd43691;
	localparam int unsigned RECIP3_SH = 17;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_MAGIC1,
		PH_MAGIC2,
		PH_SKIP,
		PH_DIGITS,
		PH_DATA,
		PH_STOP
	} phase_t;

	// Sample planes.
	typedef enum logic [1:0] {
		PL_LUMA,
		PL_U,
		PL_V
	} plane_t;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_Y,
		KIND_U,
		KIND_V,
		KIND_HEADER,
		KIND_ERROR,
		KIND_END
	} kind_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_MAGIC,
		ERR_MAXVAL,
		ERR_SIZE
	} err_t;

	// One result item plus its valid flag.
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  sample;
		logic        last;
		logic [12:0] width;
		logic [11:0] height;
		err_t        err;
	} res_t;

	// Header whitespace: space, tab, LF, VT, FF, CR.
	function automatic logic is_blank(input logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Accumulator times ten plus the new digit, saturated at ACC_MAX.
	function automatic logic [15:0] acc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [19:0] v;
		logic [7:0]  d;
		d = b - CH_ZERO;
		v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {12'b0, d};
		return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[15:0];
	endfunction

	// Floor of x / 3 by reciprocal multiplication.
	function automatic logic [15:0] div3(input logic [15:0] x);
		logic [32:0] p;
		p = {17'b0, x} * {16'b0, RECIP3};
		return p[RECIP3_SH +: 16];
	endfunction

endpackage

// ===== design/pgm_p5_yuv420_stream_splitter.sv =====
// Path: a byte accepted into the input register is parsed from there, and its
// result item is loaded into the result register, which drives the outputs.
// Throughput: one byte per cycle; a byte that yields a result waits only while
// the result register is full and stalled, set by the single result register.
// Reset: arst_n clears the parser to await the first magic byte and empties
// both the input and the result registers.
// ----------------------------------------------------------------------------
// pgm_p5_yuv420_stream_splitter: PGM P5 4:2:0 stream splitter.
// Parses P5 headers from a byte stream and tags each data byte as a Y, U or
// V sample, reporting the first header, errors and the end of the stream.
// ----------------------------------------------------------------------------
module pgm_p5_yuv420_stream_splitter
	import pyss_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  kind,
	output logic [7:0]  sample,
	output logic        frame_last,
	output logic [12:0] frame_width,
	output logic [11:0] frame_height,
	output logic [1:0]  error_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       out_ready;
	res_t       res;
	res_t       res_q;

	// A byte moves on unless its result finds the result register blocked.
	assign adv = valid_s1 & (out_ready | ~res.valid);

	pyss_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.in_byte    (in_byte),
		.adv        (adv),
		.byte_stall (byte_stall),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	pyss_parser #(
		.MAX_DIM (MAX_DIM)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	pyss_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv & res.valid),
		.res_i        (res),
		.result_stall (result_stall),
		.ready        (out_ready),
		.valid_q      (result_valid),
		.res_q        (res_q)
	);

	// Result fields.
	assign kind         = res_q.kind;
	assign sample       = res_q.sample;
	assign frame_last   = res_q.last;
	assign frame_width  = res_q.width;
	assign frame_height = res_q.height;
	assign error_code   = res_q.err;

endmodule

// ===== design/pyss_in_reg.sv =====
// ----------------------------------------------------------------------------
// pyss_in_reg: input register of the stream splitter.
// Captures one stream byte per cycle and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module pyss_in_reg
	import pyss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] in_byte,
	input  logic       adv,
	output logic       byte_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	// The stage is free when empty or when its item moves on this cycle.
	assign byte_stall = valid_s1 & ~adv;
	assign take       = byte_valid & ~byte_stall;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~adv);
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== design/pyss_parser.sv =====
// ----------------------------------------------------------------------------
// pyss_parser: header parser and plane tagger.
// Holds the stream state and, from the registered byte, works out the next
// state and the result item of that byte in one pass.
// ----------------------------------------------------------------------------
module pyss_parser
	import pyss_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] byte_s1,
	output res_t       res
);

	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

	// State registers.
	phase_t             phase_q,   phase_n;
	logic [7:0]         magic_q,   magic_n;
	logic [1:0]         fidx_q,    fidx_n;
	logic               cmt_q,     cmt_n;
	logic [15:0]        acc_q,     acc_n;
	logic [15:0]        cols_q,    cols_n;
	logic [15:0]        rows_q,    rows_n;
	logic               first_q,   first_n;
	logic [DIM_W-1:0]   sw_q,      sw_n;
	logic [DIM_W-1:0]   sh_q,      sh_n;
	logic [DIM_W-1:0]   row_q,     row_n;
	logic [DIM_W-1:0]   col_q,     col_n;
	plane_t             plane_q,   plane_n;

	// Working values.
	logic               fe;
	logic [15:0]        fe_val;
	logic               last;
	logic [DIM_W-1:0]   col_inc;
	logic [DIM_W-1:0]   row_inc;
	logic [DIM_W-1:0]   half_w;
	logic [DIM_W-1:0]   half_h;
	logic               chroma;
	logic [15:0]        height_full;
	logic [15:0]        sw16;
	logic [15:0]        sh16;

	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign half_w  = sw_q >> 1;
	assign half_h  = sh_q >> 1;
	assign chroma  = (half_w != '0) && (half_h != '0);

	// Luma height of the first header: rows * 2 / 3.
	assign height_full = div3({rows_q[14:0], 1'b0});

	// Next state and result of the byte in the input register.
	always_comb begin
		phase_n = phase_q;
		magic_n = magic_q;
		fidx_n  = fidx_q;
		cmt_n   = cmt_q;
		acc_n   = acc_q;
		cols_n  = cols_q;
		rows_n  = rows_q;
		first_n = first_q;
		sw_n    = sw_q;
		sh_n    = sh_q;
		row_n   = row_q;
		col_n   = col_q;
		plane_n = plane_q;
		fe      = 1'b0;
		fe_val  = acc_q;
		last    = 1'b0;
		sw16    = '0;
		sh16    = '0;
		res     = '0;

		unique case (phase_q)
			PH_MAGIC1: begin
				magic_n = byte_s1;
				phase_n = PH_MAGIC2;
			end
			PH_MAGIC2: begin
				if ((magic_q != CH_P) || (byte_s1 != CH_5)) begin
					phase_n   = PH_STOP;
					res.valid = 1'b1;
					res.kind  = first_q ? KIND_END : KIND_ERROR;
					res.err   = ERR_MAGIC;
				end else begin
					fidx_n  = FIELD_COLS;
					cmt_n   = 1'b0;
					acc_n   = '0;
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				priority if (cmt_q) begin
					if (byte_s1 == CH_LF) begin
						cmt_n = 1'b0;
					end
				end else if (byte_s1 == CH_HASH) begin
					cmt_n = 1'b1;
				end else if (is_blank(byte_s1)) begin
					// Whitespace between fields is skipped.
				end else if (!is_digit(byte_s1)) begin
					// A field that opens with a non-digit reads as saturated.
					acc_n  = ACC_MAX;
					fe     = 1'b1;
					fe_val = ACC_MAX;
				end else begin
					acc_n   = {8'b0, byte_s1 - CH_ZERO};
					phase_n = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (is_digit(byte_s1)) begin
					acc_n = acc_step(acc_q, byte_s1);
				end else begin
					fe     = 1'b1;
					fe_val = acc_q;
				end
			end
			PH_DATA: begin
				res.valid  = 1'b1;
				res.sample = byte_s1;
				unique case (plane_q)
					PL_LUMA: begin
						res.kind = KIND_Y;
						if (col_inc >= sw_q) begin
							col_n = '0;
							if (row_inc >= sh_q) begin
								row_n = '0;
								if (chroma) begin
									plane_n = PL_U;
								end else begin
									last = 1'b1;
								end
							end else begin
								row_n = row_inc;
							end
						end else begin
							col_n = col_inc;
						end
					end
					PL_U: begin
						res.kind = KIND_U;
						if (col_inc >= half_w) begin
							col_n   = '0;
							plane_n = PL_V;
						end else begin
							col_n = col_inc;
						end
					end
					PL_V: begin
						res.kind = KIND_V;
						if (col_inc >= half_w) begin
							col_n   = '0;
							plane_n = PL_U;
							row_n   = row_inc;
							if (row_inc >= half_h) begin
								last = 1'b1;
							end
						end else begin
							col_n = col_inc;
						end
					end
					default: begin
						res.valid = 1'b0;
					end
				endcase
				// End of frame: wait for the next magic.
				if (last) begin
					plane_n = PL_LUMA;
					row_n   = '0;
					col_n   = '0;
					phase_n = PH_MAGIC1;
				end
				res.last = last;
			end
			PH_STOP: begin
				// Stopped for good.
			end
			default: begin
				phase_n = PH_STOP;
			end
		endcase

		// A completed header field.
		if (fe) begin
			unique case (fidx_q)
				FIELD_COLS: begin
					cols_n  = fe_val;
					fidx_n  = FIELD_ROWS;
					acc_n   = '0;
					phase_n = PH_SKIP;
				end
				FIELD_ROWS: begin
					rows_n  = fe_val;
					fidx_n  = FIELD_MAXV;
					acc_n   = '0;
					phase_n = PH_SKIP;
				end
				default: begin
					// Maxval closes the header.
					priority if (first_q) begin
						// Later headers only restart the frame.
						plane_n = PL_LUMA;
						row_n   = '0;
						col_n   = '0;
						phase_n = ((sw_q == '0) || (sh_q == '0)) ? PH_MAGIC1 : PH_DATA;
					end else if (fe_val != MAXVAL_OK) begin
						phase_n   = PH_STOP;
						res.valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_MAXVAL;
					end else if ((cols_q > 16'(MAX_DIM)) || (rows_q > 16'(MAX_DIM))) begin
						phase_n   = PH_STOP;
						res.valid = 1'b1;
						res.kind  = KIND_ERROR;
						res.err   = ERR_SIZE;
					end else begin
						first_n    = 1'b1;
						sw_n       = cols_q[DIM_W-1:0];
						sh_n       = height_full[DIM_W-1:0];
						plane_n    = PL_LUMA;
						row_n      = '0;
						col_n      = '0;
						phase_n    = ((sw_n == '0) || (sh_n == '0)) ? PH_MAGIC1 : PH_DATA;
						sw16       = 16'(sw_n);
						sh16       = 16'(sh_n);
						res.valid  = 1'b1;
						res.kind   = KIND_HEADER;
						res.width  = sw16[12:0];
						res.height = sh16[11:0];
					end
				end
			endcase
		end
	end

	// State update, once per byte that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC1;
			magic_q <= '0;
			fidx_q  <= FIELD_COLS;
			cmt_q   <= 1'b0;
			acc_q   <= '0;
			cols_q  <= '0;
			rows_q  <= '0;
			first_q <= 1'b0;
			sw_q    <= '0;
			sh_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
			plane_q <= PL_LUMA;
		end else if (adv) begin
			phase_q <= phase_n;
			magic_q <= magic_n;
			fidx_q  <= fidx_n;
			cmt_q   <= cmt_n;
			acc_q   <= acc_n;
			cols_q  <= cols_n;
			rows_q  <= rows_n;
			first_q <= first_n;
			sw_q    <= sw_n;
			sh_q    <= sh_n;
			row_q   <= row_n;
			col_q   <= col_n;
			plane_q <= plane_n;
		end
	end

endmodule

// ===== design/pyss_out_reg.sv =====
// ----------------------------------------------------------------------------
// pyss_out_reg: result register of the stream splitter.
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module pyss_out_reg
	import pyss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_i,
	input  logic result_stall,
	output logic ready,
	output logic valid_q,
	output res_t res_q
);

	// The register can take a new item when empty or being emptied.
	assign ready = ~valid_q | ~result_stall;

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_i;
		end
	end

endmodule

// ===== design/pyss_checker.sv =====
// ----------------------------------------------------------------------------
// pyss_checker: port-level checks of the stream splitter.
// Watches the result channel for stop behavior, header uniqueness and order,
// the placement of the end-of-frame mark and the hold of stalled items.
// ----------------------------------------------------------------------------
module pyss_checker
	import pyss_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [2:0]  kind,
	input logic [7:0]  sample,
	input logic        frame_last
);

	logic out_take;
	logic stopped_q;
	logic header_seen_q;

	assign out_take = result_valid & ~result_stall;

	// Track a delivered stop and a delivered header.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q     <= 1'b0;
			header_seen_q <= 1'b0;
		end else if (out_take) begin
			if ((kind == KIND_ERROR) || (kind == KIND_END)) begin
				stopped_q <= 1'b1;
			end
			if (kind == KIND_HEADER) begin
				header_seen_q <= 1'b1;
			end
		end
	end

	// After an error or end of stream no further item appears.
	a_stop_final: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !result_valid)
		else $error("result item after stop");

	// The header is reported at most once.
	a_one_header: assert property (@(posedge clk) disable iff (!arst_n)
		(header_seen_q && result_valid) |-> (kind != KIND_HEADER))
		else $error("second header item");

	// The end-of-frame mark rides only on samples.
	a_last_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frame_last) |->
			((kind == KIND_Y) || (kind == KIND_U) || (kind == KIND_V)))
		else $error("frame_last on a non-sample item");

	// Samples only arrive after the header has been delivered.
	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && ((kind == KIND_Y) || (kind == KIND_U) || (kind == KIND_V)))
			|-> header_seen_q)
		else $error("sample item before header");

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(kind) && $stable(sample)))
		else $error("stalled result changed");

endmodule

bind pgm_p5_yuv420_stream_splitter pyss_checker u_pyss_checker (.*);
